// ===== design/qapm_pkg.sv =====
// Package for the quadrotor attitude PD mixer: sequencer states, register codes,
// loop gains, mixer signs, the cosine table builder and saturation helpers.
// No dependencies.
`default_nettype none

package qapm_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int COS_N          = 1 << COS_TABLE_BITS;

  typedef logic [COS_TABLE_BITS:0] cos_idx_t;
  typedef logic signed [31:0] cos_rom_t [COS_N+1];
  typedef logic signed [19:0] coef_t;

  typedef enum logic [4:0] {
    S_IDLE, S_IDXA, S_IDXB, S_COSA, S_COSB, S_CCLO, S_CCHI, S_DIV, S_GSAT,
    S_DZ, S_DDZ, S_REF, S_PTERM, S_DTERM, S_MIX,
    S_CDQ, S_CSTEP, S_CDQREF, S_CP, S_CD, S_DONE
  } seq_state_t;

  localparam logic [1:0] REG_INV_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_HOVER_FORCE    = 2'd1;
  localparam logic [1:0] REG_STICK_DEADBAND = 2'd2;

  localparam logic [15:0] INV_TIME_STEP_RST  = 16'd1000;
  localparam logic [30:0] HOVER_FORCE_RST    = 31'd160672;
  localparam logic [14:0] STICK_DEADBAND_RST = 15'd8192;

  localparam longint ONE_Q30  = 64'sd1 <<< 30;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam logic signed [32:0] PI_Q16 = 33'sd205887;
  localparam logic signed [39:0] INV_PI_Q32 = 40'sd1367130551;
  localparam logic signed [39:0] CAM_STEP_Q = 40'sd4294967;
  localparam coef_t CAM_P = 20'sd85899;
  localparam coef_t CAM_D = 20'sd171799;
  localparam longint COS_RND = 64'sd1 <<< (47 - COS_TABLE_BITS);

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
  localparam logic signed [63:0] MAX48 = 64'sd140737488355327;
  localparam logic signed [63:0] MIN48 = -64'sd140737488355328;

  localparam coef_t KP_TAB   [4] = '{20'sd26214, 20'sd26214, 20'sd26214, 20'sd65536};
  localparam coef_t KD_TAB   [4] = '{20'sd1311, 20'sd65536, 20'sd65536, 20'sd3277};
  localparam coef_t RATE_TAB [4] = '{-20'sd65536, 20'sd6554, -20'sd6554, -20'sd32768};

  // bit j set: loop output j enters rotor i with a minus sign
  localparam logic [3:0] MIX_NEG [4] = '{4'b0110, 4'b1100, 4'b0000, 4'b1010};
  localparam logic [3:0] SPIN_NEG = 4'b1010;

  localparam longint TAYLOR_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

  function automatic cos_rom_t build_cos_tab();
    cos_rom_t tab;
    longint x, x2, t;
    for (int k = 0; k <= COS_N / 2; k++) begin
      x  = longint'((longint'(k) * PI_Q30) >>> COS_TABLE_BITS);
      x2 = (x * x) >>> 30;
      t  = ONE_Q30;
      for (int j = 0; j < 7; j++) begin
        t = ONE_Q30 - ((x2 * t) >>> 30) / TAYLOR_DIV[j];
      end
      if (t < 0) begin
        t = 0;
      end
      tab[k] = t[31:0];
    end
    for (int k = COS_N / 2 + 1; k <= COS_N; k++) begin
      tab[k] = -tab[COS_N - k];
    end
    return tab;
  endfunction

  function automatic logic signed [39:0] to40(input logic signed [63:0] v);
    return v[39:0];
  endfunction

  function automatic logic signed [19:0] to20(input logic signed [63:0] v);
    return v[19:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > MAX32) begin
      return MAX32[31:0];
    end else if (v < MIN32) begin
      return MIN32[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] satsym32(input logic signed [63:0] v);
    if (v > MAX32) begin
      return MAX32[31:0];
    end else if (v < -MAX32) begin
      return 32'sh80000001;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > MAX48) begin
      return MAX48[47:0];
    end else if (v < MIN48) begin
      return MIN48[47:0];
    end
    return v[47:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/quadrotor_attitude_pd_mixer.sv =====
// Top level of the quadrotor attitude PD mixer: APB register file, sequencer,
// shared 40x20 multiplier, serial divider and cosine ROM. Depends on qapm_pkg.
//
// Usage: one input beat per control tick carries the pose, four sticks, the
// power button and the camera pad and joint angle. Each tick yields exactly one
// output beat with four rotor forces, their torques, the rotor enable state and
// the camera drive. Both channels use valid/ready; the result sits in an output
// register, so a stalled receiver holds the sequencer only once a new result waits.
// in_ready is high only while the sequencer is idle.
// Steps: a tick with rotors on runs the index passes through the shared multiplier,
// the ROM reads, the cosine product, the bit-serial feed-forward divide, one
// saturation step, five multiply passes per axis, the mixer steps, up to five
// camera passes and the output step. With rotors off a tick runs only the camera
// passes and the output step; the camera step passes run only while the camera
// pad is active. The next beat is taken the cycle after the result is loaded into
// the output register; if that register is still full, the sequencer waits in its
// last step.
// Reset (rst_n low, synchronous) drops the rotors, clears the button latch and
// the primed flag and restores register defaults; the first tick after reset
// loads the previous-pose and camera history from its own values.
// Registers: inv_time_step at 0x0, hover_force at 0x4, stick_deadband at 0x8.
`default_nettype none

module quadrotor_attitude_pd_mixer
  import qapm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_height,
  input  wire logic signed [18:0] in_roll,
  input  wire logic signed [18:0] in_pitch,
  input  wire logic signed [18:0] in_yaw,
  input  wire logic signed [15:0] in_stick_climb,
  input  wire logic signed [15:0] in_stick_roll,
  input  wire logic signed [15:0] in_stick_pitch,
  input  wire logic signed [15:0] in_stick_yaw,
  input  wire logic               in_power_button,
  input  wire logic signed [15:0] in_camera_pad,
  input  wire logic signed [19:0] in_camera_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_force_front_left,
  output logic signed [31:0]      out_force_front_right,
  output logic signed [31:0]      out_force_rear_right,
  output logic signed [31:0]      out_force_rear_left,
  output logic signed [31:0]      out_torque_front_left,
  output logic signed [31:0]      out_torque_front_right,
  output logic signed [31:0]      out_torque_rear_right,
  output logic signed [31:0]      out_torque_rear_left,
  output logic                    out_rotors_on,
  output logic signed [47:0]      out_camera_drive
);

  localparam cos_rom_t COS_TAB = build_cos_tab();

  // control state
  seq_state_t state_r, state_nxt;
  logic       ph_r, ph_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       primed_r, rotor_r, held_r, rotor_nxt, held_nxt;
  logic       out_valid_r;

  // configuration
  logic [15:0] inv_r;
  logic [30:0] hover_r;
  logic [14:0] db_r;

  // tick operands and history
  logic signed [31:0] pose_r      [4];
  logic signed [15:0] stk_r       [4];
  logic signed [15:0] pad_r;
  logic signed [19:0] q_r;
  logic signed [31:0] last_pose_r [4];
  logic signed [31:0] last_rate_r [4];
  logic signed [31:0] cam_tgt_r, cam_last_r;

  // working registers
  cos_idx_t           idx_a_r, idx_b_r, rom_addr, idx_raw, idx_fold;
  logic signed [31:0] rom_q_r, ca_r, cc_r, g_r;
  logic signed [63:0] acc_r, p64;
  logic signed [59:0] prod_r;
  logic        [60:0] quo_r;
  logic        [30:0] rem_r, dv;
  logic        [31:0] rem_sh;
  logic               ge;
  logic signed [31:0] dz_r, ddz_r, ref_r;
  logic signed [31:0] f_r     [4];
  logic signed [31:0] force_r [4];
  logic signed [39:0] dq_r, dqref_r;
  logic signed [31:0] step_r, step_c;
  logic signed [47:0] drive_r;

  logic signed [31:0] out_force_r  [4];
  logic signed [31:0] out_torque_r [4];
  logic               out_rot_r;
  logic signed [47:0] out_drive_r;

  // shared multiplier operands
  logic signed [39:0] mul_a;
  logic signed [19:0] mul_b;

  logic               accept, mul_st, adv, wb, jump, stk_act, pos_act, out_free;
  logic signed [31:0] lane_pose, lane_last, lane_rate;
  logic signed [15:0] lane_stk;
  logic signed [32:0] diff33;
  logic signed [16:0] db_s, pos17;
  logic signed [19:0] abs_roll, abs_pitch;
  logic signed [63:0] idx_sum, mix_sum, stp_full, tgt64;
  logic signed [31:0] tgt_c;
  logic               lane_rate_loop;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE);
  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // ---------------- configuration port ----------------
  always_comb begin
    unique case (paddr[3:2])
      REG_INV_TIME_STEP:  prdata = {16'd0, inv_r};
      REG_HOVER_FORCE:    prdata = {1'b0, hover_r};
      REG_STICK_DEADBAND: prdata = {17'd0, db_r};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------- lane operand selection ----------------
  assign lane_pose      = pose_r[lane_r];
  assign lane_last      = last_pose_r[lane_r];
  assign lane_rate      = last_rate_r[lane_r];
  assign lane_stk       = stk_r[lane_r];
  // height and yaw run a rate loop; roll and pitch an angle loop
  assign lane_rate_loop = (lane_r == 2'd0) || (lane_r == 2'd3);
  assign diff33         = 33'(lane_pose) - 33'(lane_last);
  // a jump beyond pi reads as a wrap, not a motion: zero the rate
  assign jump           = (diff33 > PI_Q16) || (diff33 < -PI_Q16);
  assign db_s           = {2'b00, db_r};
  assign stk_act        = (lane_stk > db_s) || (lane_stk < -db_s);
  assign pos17          = 17'sd0 - 17'(pad_r);
  assign pos_act        = (pos17 > db_s) || (pos17 < -db_s);
  assign abs_roll       = to20(pose_r[1] < 0 ? -pose_r[1] : pose_r[1]);
  assign abs_pitch      = to20(pose_r[2] < 0 ? -pose_r[2] : pose_r[2]);

  // ---------------- shared multiplier ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_IDXA: begin
        mul_a = INV_PI_Q32;
        mul_b = abs_roll;
      end
      S_IDXB: begin
        mul_a = INV_PI_Q32;
        mul_b = abs_pitch;
      end
      S_CCLO: begin
        // low half of the second cosine, unsigned
        mul_a = to40(ca_r);
        mul_b = {5'd0, rom_q_r[14:0]};
      end
      S_CCHI: begin
        mul_a = to40(ca_r);
        mul_b = to20(rom_q_r >>> 15);
      end
      S_DZ: begin
        mul_a = to40(diff33);
        mul_b = to20(inv_r);
      end
      S_DDZ: begin
        mul_a = to40(dz_r - lane_rate);
        mul_b = to20(inv_r);
      end
      S_REF: begin
        mul_a = to40(lane_stk);
        mul_b = RATE_TAB[lane_r];
      end
      S_PTERM: begin
        mul_a = lane_rate_loop ? to40(ref_r - dz_r) : to40(ref_r - lane_pose);
        mul_b = KP_TAB[lane_r];
      end
      S_DTERM: begin
        mul_a = lane_rate_loop ? to40(ddz_r) : to40(dz_r);
        mul_b = KD_TAB[lane_r];
      end
      S_CDQ: begin
        mul_a = to40(q_r - cam_last_r);
        mul_b = to20(inv_r);
      end
      S_CSTEP: begin
        mul_a = CAM_STEP_Q;
        mul_b = to20(pos17);
      end
      S_CDQREF: begin
        mul_a = to40(step_r);
        mul_b = to20(inv_r);
      end
      S_CP: begin
        mul_a = to40(cam_tgt_r - q_r);
        mul_b = CAM_P;
      end
      S_CD: begin
        mul_a = to40(dqref_r - dq_r);
        mul_b = CAM_D;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p64 = 64'(prod_r);

  // cosine index: round to nearest entry, then fold the upper half
  assign idx_sum  = p64 + COS_RND;
  assign idx_raw  = idx_sum[48 -: COS_TABLE_BITS + 1];
  assign idx_fold = (idx_raw > cos_idx_t'(COS_N)) ? cos_idx_t'(2 * COS_N - int'(idx_raw))
                                                   : idx_raw;
  assign rom_addr = (state_r == S_COSA) ? idx_a_r : idx_b_r;

  // serial divider step
  assign dv     = cc_r[31] ? 31'(-cc_r) : cc_r[30:0];
  assign rem_sh = {rem_r, quo_r[60]};
  assign ge     = rem_sh >= {1'b0, dv};

  // camera target step and clamp; a full pad swing steps by up to 131
  assign stp_full = (p64 + (64'sd1 <<< 29)) >>> 30;
  assign step_c   = stp_full[31:0];
  assign tgt64    = 64'(cam_tgt_r) + 64'(step_c);
  always_comb begin
    if (tgt64 > 0) begin
      tgt_c = '0;
    end else if (tgt64 < -PI_Q16) begin
      tgt_c = -32'sd205887;
    end else begin
      tgt_c = tgt64[31:0];
    end
  end

  // mixer: hover feed-forward plus signed loop outputs for one rotor
  always_comb begin
    mix_sum = 64'(g_r);
    for (int j = 0; j < 4; j++) begin
      mix_sum = MIX_NEG[lane_r][j] ? (mix_sum - f_r[j]) : (mix_sum + f_r[j]);
    end
  end

  // rotor toggle on a rising edge of the button
  always_comb begin
    rotor_nxt = rotor_r;
    held_nxt  = held_r;
    if (!in_power_button) begin
      held_nxt = 1'b0;
    end else if (!held_r) begin
      rotor_nxt = !rotor_r;
      held_nxt  = 1'b1;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    unique case (state_r)
      S_IDXA, S_IDXB, S_CCLO, S_CCHI, S_DZ, S_DDZ, S_REF, S_PTERM, S_DTERM,
      S_CDQ, S_CSTEP, S_CDQREF, S_CP, S_CD: mul_st = 1'b1;
      default:                              mul_st = 1'b0;
    endcase
  end

  // a multiply step issues in phase 0 and writes back in phase 1
  assign adv = !mul_st || ph_r;
  assign wb  = mul_st && ph_r;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = mul_st && !ph_r;
    lane_nxt  = lane_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = rotor_nxt ? S_IDXA : S_CDQ;
        end
      end
      S_IDXA:  if (adv) state_nxt = S_IDXB;
      S_IDXB:  state_nxt = adv ? S_COSA : S_IDXB;
      S_COSA:  state_nxt = S_COSB;
      S_COSB:  state_nxt = S_CCLO;
      S_CCLO:  if (adv) state_nxt = S_CCHI;
      S_CCHI: begin
        if (adv) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd60) begin
          state_nxt = S_GSAT;
        end
      end
      S_GSAT: begin
        state_nxt = S_DZ;
        lane_nxt  = 2'd0;
      end
      S_DZ:    if (adv) state_nxt = S_DDZ;
      S_DDZ:   if (adv) state_nxt = S_REF;
      S_REF:   if (adv) state_nxt = S_PTERM;
      S_PTERM: if (adv) state_nxt = S_DTERM;
      S_DTERM: begin
        if (adv) begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = (lane_r == 2'd3) ? S_MIX : S_DZ;
        end
      end
      S_MIX: begin
        lane_nxt = lane_r + 2'd1;
        if (lane_r == 2'd3) begin
          state_nxt = S_CDQ;
        end
      end
      S_CDQ:    if (adv) state_nxt = pos_act ? S_CSTEP : S_CP;
      S_CSTEP:  if (adv) state_nxt = S_CDQREF;
      S_CDQREF: if (adv) state_nxt = S_CP;
      S_CP:     if (adv) state_nxt = S_CD;
      S_CD:     if (adv) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 1'b0;
      lane_r      <= 2'd0;
      cnt_r       <= 6'd0;
      primed_r    <= 1'b0;
      rotor_r     <= 1'b0;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
      inv_r       <= INV_TIME_STEP_RST;
      hover_r     <= HOVER_FORCE_RST;
      db_r        <= STICK_DEADBAND_RST;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      lane_r  <= lane_nxt;
      cnt_r   <= cnt_nxt;
      if (accept) begin
        primed_r <= 1'b1;
        rotor_r  <= rotor_nxt;
        held_r   <= held_nxt;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_INV_TIME_STEP:  inv_r   <= pwdata[15:0];
          REG_HOVER_FORCE:    hover_r <= pwdata[30:0];
          REG_STICK_DEADBAND: db_r    <= pwdata[14:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    rom_q_r <= COS_TAB[rom_addr];

    if (accept) begin
      pose_r[0] <= in_height;
      pose_r[1] <= in_roll;
      pose_r[2] <= in_pitch;
      pose_r[3] <= in_yaw;
      stk_r[0]  <= in_stick_climb;
      stk_r[1]  <= in_stick_roll;
      stk_r[2]  <= in_stick_pitch;
      stk_r[3]  <= in_stick_yaw;
      pad_r     <= in_camera_pad;
      q_r       <= in_camera_angle;
      // first tick after reset: seed the history from this tick
      if (!primed_r) begin
        last_pose_r[0] <= in_height;
        last_pose_r[1] <= in_roll;
        last_pose_r[2] <= in_pitch;
        last_pose_r[3] <= in_yaw;
        for (int i = 0; i < 4; i++) begin
          last_rate_r[i] <= '0;
        end
        cam_tgt_r  <= in_camera_angle;
        cam_last_r <= in_camera_angle;
      end
    end

    unique case (state_r)
      S_IDXA: if (wb) idx_a_r <= idx_fold;
      S_IDXB: if (wb) idx_b_r <= idx_fold;
      S_COSB: ca_r <= rom_q_r;
      S_CCLO: if (wb) acc_r <= p64;
      S_CCHI: begin
        if (wb) begin
          cc_r  <= 32'(((p64 <<< 15) + acc_r) >>> 30);
          quo_r <= {hover_r, 30'd0};
          rem_r <= '0;
        end
      end
      S_DIV: begin
        quo_r <= {quo_r[59:0], ge};
        rem_r <= ge ? 31'(rem_sh - {1'b0, dv}) : rem_sh[30:0];
      end
      S_GSAT: begin
        // truncating divide, sign from the cosine product, saturate to 32 bits
        if (cc_r == 0) begin
          g_r <= MAX32[31:0];
        end else if (!cc_r[31]) begin
          g_r <= (quo_r > 61'(MAX32)) ? MAX32[31:0] : quo_r[31:0];
        end else begin
          g_r <= (quo_r > 61'(MAX32) + 61'd1) ? MIN32[31:0] : 32'(-quo_r);
        end
      end
      S_DZ:  if (wb) dz_r <= jump ? '0 : sat32(p64);
      S_DDZ: if (wb) ddz_r <= sat32(p64);
      S_REF: begin
        if (wb) begin
          ref_r <= stk_act ? 32'((p64 + 64'sd16384) >>> 15) : '0;
        end
      end
      S_PTERM: if (wb) acc_r <= p64;
      S_DTERM: begin
        if (wb) begin
          f_r[lane_r]         <= sat32((acc_r - p64 + 64'sd32768) >>> 16);
          last_pose_r[lane_r] <= lane_pose;
          last_rate_r[lane_r] <= dz_r;
        end
      end
      S_MIX: force_r[lane_r] <= satsym32(mix_sum);
      S_CDQ: begin
        if (wb) begin
          dq_r    <= p64[39:0];
          dqref_r <= '0;
        end
      end
      S_CSTEP: begin
        if (wb) begin
          step_r    <= step_c;
          cam_tgt_r <= tgt_c;
        end
      end
      S_CDQREF: if (wb) dqref_r <= p64[39:0];
      S_CP:     if (wb) acc_r <= p64;
      S_CD: begin
        if (wb) begin
          drive_r    <= sat48((acc_r + p64 + 64'sd32768) >>> 16);
          cam_last_r <= q_r;
        end
      end
      S_DONE: begin
        if (out_free) begin
          for (int i = 0; i < 4; i++) begin
            out_force_r[i]  <= rotor_r ? force_r[i] : '0;
            out_torque_r[i] <= !rotor_r ? '0 : (SPIN_NEG[i] ? -force_r[i] : force_r[i]);
          end
          out_rot_r   <= rotor_r;
          out_drive_r <= drive_r;
        end
      end
      default: ;
    endcase
  end

  assign out_force_front_left   = out_force_r[0];
  assign out_force_front_right  = out_force_r[1];
  assign out_force_rear_right   = out_force_r[2];
  assign out_force_rear_left    = out_force_r[3];
  assign out_torque_front_left  = out_torque_r[0];
  assign out_torque_front_right = out_torque_r[1];
  assign out_torque_rear_right  = out_torque_r[2];
  assign out_torque_rear_left   = out_torque_r[3];
  assign out_rotors_on          = out_rot_r;
  assign out_camera_drive       = out_drive_r;

endmodule

`default_nettype wire

// ===== tb/qapm_checker.sv =====
// Checker for the quadrotor attitude PD mixer: tracks register writes, predicts
// one result per accepted tick and compares every output beat field by field.
// Depends on qapm_pkg for the register codes.
`default_nettype none

module qapm_checker
  import qapm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [31:0] in_height,
  input  wire logic signed [18:0] in_roll,
  input  wire logic signed [18:0] in_pitch,
  input  wire logic signed [18:0] in_yaw,
  input  wire logic signed [15:0] in_stick_climb,
  input  wire logic signed [15:0] in_stick_roll,
  input  wire logic signed [15:0] in_stick_pitch,
  input  wire logic signed [15:0] in_stick_yaw,
  input  wire logic               in_power_button,
  input  wire logic signed [15:0] in_camera_pad,
  input  wire logic signed [19:0] in_camera_angle,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] out_force_front_left,
  input  wire logic signed [31:0] out_force_front_right,
  input  wire logic signed [31:0] out_force_rear_right,
  input  wire logic signed [31:0] out_force_rear_left,
  input  wire logic signed [31:0] out_torque_front_left,
  input  wire logic signed [31:0] out_torque_front_right,
  input  wire logic signed [31:0] out_torque_rear_right,
  input  wire logic signed [31:0] out_torque_rear_left,
  input  wire logic               out_rotors_on,
  input  wire logic signed [47:0] out_camera_drive,
  output int                      fail_count,
  output int                      results_due,
  output int                      results_seen,
  output int                      powered_seen
);

  localparam int TBL_BITS = 10;
  localparam int TBL_N    = 1 << TBL_BITS;
  localparam longint Q30  = 64'sd1 <<< 30;
  localparam longint LIM32 = 64'sd2147483647;
  localparam longint LIM48 = (64'sd1 <<< 47) - 1;

  localparam longint P_GAIN [4] = '{26214, 26214, 26214, 65536};
  localparam longint D_GAIN [4] = '{1311, 65536, 65536, 3277};
  localparam longint STICK_SCALE [4] = '{-65536, 6554, -6554, -32768};
  localparam longint SERIES_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

  typedef struct {
    logic signed [31:0] force_q [4];
    logic signed [31:0] torque_q [4];
    logic               rotors;
    logic signed [47:0] cam_drive;
  } tick_result_t;

  tick_result_t tick_results_due [$];

  longint cos_rom [TBL_N+1];

  logic [15:0] ticks_per_sec;
  logic [30:0] hover_q16;
  logic [14:0] deadband_q15;
  bit          primed, rotors_enabled, button_latched;
  longint      prev_pose [4], prev_rate [4], cam_target, cam_prev;

  initial begin
    longint x, x2, t;
    fail_count = 0;
    results_due = 0;
    results_seen = 0;
    powered_seen = 0;
    for (int k = 0; k <= TBL_N / 2; k++) begin
      x  = (longint'(k) * 64'sd3373259426) >>> TBL_BITS;
      x2 = (x * x) >>> 30;
      t  = Q30;
      for (int j = 0; j < 7; j++) begin
        t = Q30 - ((x2 * t) >>> 30) / SERIES_DIV[j];
      end
      cos_rom[k] = (t < 0) ? 0 : t;
    end
    for (int k = TBL_N / 2 + 1; k <= TBL_N; k++) begin
      cos_rom[k] = -cos_rom[TBL_N - k];
    end
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // round to nearest, ties upward
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint cos_of(longint a);
    longint idx;
    idx = (mag(a) * 64'sd1367130551 + (64'sd1 <<< (47 - TBL_BITS))) >>> (48 - TBL_BITS);
    if (idx > 2 * TBL_N) begin
      idx = 2 * TBL_N;
    end
    if (idx > TBL_N) begin
      idx = 2 * TBL_N - idx;
    end
    return cos_rom[idx];
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    fail_count++;
    $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  task automatic compute_tick();
    longint pose [4], stk [4], loop_out [4], frc [4];
    longint inv, db, cc, ff, diff, dz, ddz, stick_ref, acc, sum;
    longint q, pad_pos, dq, dqref, step, tgt, drv;
    tick_result_t r;
    inv = ticks_per_sec;
    db  = deadband_q15;
    pose[0] = in_height;
    pose[1] = in_roll;
    pose[2] = in_pitch;
    pose[3] = in_yaw;
    stk[0] = in_stick_climb;
    stk[1] = in_stick_roll;
    stk[2] = in_stick_pitch;
    stk[3] = in_stick_yaw;
    q = in_camera_angle;
    for (int i = 0; i < 4; i++) begin
      frc[i] = 0;
    end

    if (!primed) begin
      for (int i = 0; i < 4; i++) begin
        prev_pose[i] = pose[i];
        prev_rate[i] = 0;
      end
      cam_target = q;
      cam_prev = q;
      primed = 1;
    end

    if (!in_power_button) begin
      button_latched = 0;
    end else if (!button_latched) begin
      rotors_enabled = !rotors_enabled;
      button_latched = 1;
    end

    if (rotors_enabled) begin
      cc = (cos_of(pose[1]) * cos_of(pose[2])) >>> 30;
      ff = (cc == 0) ? LIM32 : clip((longint'(hover_q16) <<< 30) / cc, -LIM32 - 1, LIM32);
      for (int i = 0; i < 4; i++) begin
        diff = pose[i] - prev_pose[i];
        dz = (mag(diff) > 205887) ? 0 : clip(diff * inv, -LIM32 - 1, LIM32);
        ddz = clip((dz - prev_rate[i]) * inv, -LIM32 - 1, LIM32);
        stick_ref = (mag(stk[i]) > db) ? round_shift(STICK_SCALE[i] * stk[i], 15) : 0;
        if (i == 0 || i == 3) begin
          acc = P_GAIN[i] * (stick_ref - dz) - D_GAIN[i] * ddz;
        end else begin
          acc = P_GAIN[i] * (stick_ref - pose[i]) - D_GAIN[i] * dz;
        end
        loop_out[i] = clip(round_shift(acc, 16), -LIM32 - 1, LIM32);
        prev_pose[i] = pose[i];
        prev_rate[i] = dz;
      end
      // X layout: climb, roll, pitch, yaw
      frc[0] = ff + loop_out[0] - loop_out[1] - loop_out[2] + loop_out[3];
      frc[1] = ff + loop_out[0] + loop_out[1] - loop_out[2] - loop_out[3];
      frc[2] = ff + loop_out[0] + loop_out[1] + loop_out[2] + loop_out[3];
      frc[3] = ff + loop_out[0] - loop_out[1] + loop_out[2] - loop_out[3];
      for (int i = 0; i < 4; i++) begin
        frc[i] = clip(frc[i], -LIM32, LIM32);
      end
    end

    dq = (q - cam_prev) * inv;
    pad_pos = -longint'(in_camera_pad);
    dqref = 0;
    if (mag(pad_pos) > db) begin
      step = round_shift(64'sd4294967 * pad_pos, 30);
      tgt = clip(cam_target + step, -205887, 0);
      cam_target = tgt;
      dqref = step * inv;
    end
    drv = clip(round_shift(85899 * (cam_target - q) + 171799 * (dqref - dq), 16),
               -LIM48 - 1, LIM48);
    cam_prev = q;

    for (int i = 0; i < 4; i++) begin
      r.force_q[i] = frc[i];
      r.torque_q[i] = (i % 2 == 0) ? frc[i] : -frc[i];
    end
    r.rotors = rotors_enabled;
    r.cam_drive = drv;
    tick_results_due.push_back(r);
  endtask

  task automatic check_result();
    tick_result_t w;
    logic signed [31:0] gf [4], gt [4];
    gf = '{out_force_front_left, out_force_front_right, out_force_rear_right,
           out_force_rear_left};
    gt = '{out_torque_front_left, out_torque_front_right, out_torque_rear_right,
           out_torque_rear_left};
    if (tick_results_due.size() == 0) begin
      report("unexpected beat", 0, 0);
      return;
    end
    w = tick_results_due.pop_front();
    for (int i = 0; i < 4; i++) begin
      if (gf[i] !== w.force_q[i]) report($sformatf("force[%0d]", i), gf[i], w.force_q[i]);
      if (gt[i] !== w.torque_q[i]) report($sformatf("torque[%0d]", i), gt[i], w.torque_q[i]);
    end
    if (out_rotors_on !== w.rotors) report("rotors_on", out_rotors_on, w.rotors);
    if (out_camera_drive !== w.cam_drive) report("camera_drive", out_camera_drive, w.cam_drive);
    if (w.rotors) powered_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_sec  <= 16'd1000;
      hover_q16      <= 31'd160672;
      deadband_q15   <= 15'd8192;
      primed         = 0;
      rotors_enabled = 0;
      button_latched = 0;
      tick_results_due.delete();
      results_due    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INV_TIME_STEP:  ticks_per_sec <= pwdata[15:0];
          REG_HOVER_FORCE:    hover_q16 <= pwdata[30:0];
          REG_STICK_DEADBAND: deadband_q15 <= pwdata[14:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        check_result();
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready) begin
        compute_tick();
      end
      results_due <= tick_results_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Top of the quadrotor attitude PD mixer testbench: clock, reset, APB writes,
// tick stimulus and receiver stalls; the verdict comes from qapm_checker.
// Depends on qapm_pkg, qapm_checker and the block itself.
`default_nettype none

module tb_top;
  import qapm_pkg::*;

  localparam int ITEMS_PER_PHASE = 206;
  localparam int PHASES = 8;
  // quiet time after the last beat: one full rotors-on tick plus margin
  localparam int SETTLE = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_height = '0;
  logic signed [18:0] in_roll = '0, in_pitch = '0, in_yaw = '0;
  logic signed [15:0] in_stick_climb = '0, in_stick_roll = '0;
  logic signed [15:0] in_stick_pitch = '0, in_stick_yaw = '0;
  logic               in_power_button = 1'b0;
  logic signed [15:0] in_camera_pad = '0;
  logic signed [19:0] in_camera_angle = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_force_front_left, out_force_front_right;
  logic signed [31:0] out_force_rear_right, out_force_rear_left;
  logic signed [31:0] out_torque_front_left, out_torque_front_right;
  logic signed [31:0] out_torque_rear_right, out_torque_rear_left;
  logic               out_rotors_on;
  logic signed [47:0] out_camera_drive;

  int fail_count, results_due, results_seen, powered_seen;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int ticks_sent = 0;

  // free-running pose the random ticks drift around
  int   drift_height, drift_roll, drift_pitch, drift_yaw, drift_cam;
  logic button_level = 1'b0;

  always #1 clk = ~clk;

  quadrotor_attitude_pd_mixer dut (.*);

  qapm_checker checker_i (.*);

  // Stall the receiver at the current rate; zero means always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #6000000;
    $display("[quadrotor_attitude_pd_mixer] ERROR");
    $finish;
  end

  // Write one register with a setup and an access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid and wait until every result has come back, then settle.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Hold the current beat on the bus until the block takes it.
  task automatic push_beat();
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_tick(input int h, input int r, input int p, input int y,
                           input int sc, input int sr, input int sp, input int sy,
                           input bit btn, input int pad, input int cam);
    in_height       <= h;
    in_roll         <= r;
    in_pitch        <= p;
    in_yaw          <= y;
    in_stick_climb  <= sc;
    in_stick_roll   <= sr;
    in_stick_pitch  <= sp;
    in_stick_yaw    <= sy;
    in_power_button <= btn;
    in_camera_pad   <= pad;
    in_camera_angle <= cam;
    push_beat();
  endtask

  function automatic int angle_clamp(int v, int lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic int rand_stick();
    // half the time stay near the deadband edge region, else anywhere
    if ($urandom_range(1)) begin
      return int'($urandom_range(20000)) - 10000;
    end
    return int'($signed($urandom_range(65535) - 32768));
  endfunction

  // Mostly smooth flight with random sticks; now and then a jump or noise.
  task automatic random_tick();
    int dice;
    dice = $urandom_range(99);
    if ($urandom_range(99) < 4) begin
      button_level = ~button_level;
    end
    if (dice < 85) begin
      drift_height += int'($urandom_range(4000)) - 2000;
      drift_roll  = angle_clamp(drift_roll + int'($urandom_range(3000)) - 1500, 205887);
      drift_pitch = angle_clamp(drift_pitch + int'($urandom_range(3000)) - 1500, 205887);
      drift_yaw   = angle_clamp(drift_yaw + int'($urandom_range(3000)) - 1500, 205887);
      drift_cam   = angle_clamp(drift_cam + int'($urandom_range(6000)) - 3000, 411774);
    end else if (dice < 92) begin
      // jumps on roll, yaw and the camera angle; height and pitch hold still
      drift_roll = int'($urandom_range(411774)) - 205887;
      drift_yaw  = -drift_yaw;
      drift_cam  = int'($urandom_range(823548)) - 411774;
    end else begin
      drift_height = $urandom;
      drift_roll   = int'($urandom_range(411774)) - 205887;
      drift_pitch  = int'($urandom_range(411774)) - 205887;
      drift_yaw    = int'($urandom_range(411774)) - 205887;
      drift_cam    = int'($urandom_range(823548)) - 411774;
    end
    send_tick(drift_height, drift_roll, drift_pitch, drift_yaw,
              rand_stick(), rand_stick(), rand_stick(), rand_stick(), button_level,
              $urandom_range(1) ? 0 : rand_stick(), drift_cam);
  endtask

  // Register settings per phase: defaults, minimums, maximums, zero rate, random.
  task automatic load_phase_regs(input int ph);
    logic [31:0] rate, hover, db;
    case (ph)
      0: begin rate = 1000; hover = 160672; db = 8192; end
      1: begin rate = 1; hover = 0; db = 0; end
      2: begin rate = 65535; hover = 32'h7FFF_FFFF; db = 32767; end
      3: begin rate = 0; hover = 160672; db = 100; end
      default: begin
        rate  = $urandom_range(65535, 1);
        hover = $urandom_range(400000);
        db    = $urandom_range(16000);
      end
    endcase
    reg_write(REG_INV_TIME_STEP, rate);
    reg_write(REG_HOVER_FORCE, hover);
    reg_write(REG_STICK_DEADBAND, db);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: priming tick, power on, field extremes, special cases.
    send_tick(100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1000);
    send_tick(200, 10, -10, 5, 0, 0, 0, 0, 1, 0, 1000);
    send_tick(300, 10, -10, 5, 32767, -32768, 32767, -32768, 1, 0, 1000);
    send_tick(32'h7FFF_FFFF, 205887, 205887, 205887, -32768, 32767, -32768, 32767, 1,
              -32768, 411774);
    send_tick(32'h8000_0000, -205887, -205887, -205887, 8192, -8192, 8193, -8193, 0,
              32767, -411774);
    send_tick(0, 102944, 0, 0, 0, 0, 0, 0, 0, -32768, 0);
    send_tick(0, 102944, 102944, 0, 0, 0, 0, 0, 0, -32768, 0);
    send_tick(0, 150000, 10000, 0, 100, -100, 0, 0, 0, 30000, 0);
    send_tick(0, 0, 0, 200000, 0, 0, 0, 0, 0, 30000, 0);
    send_tick(1000000, 0, 0, -200000, 0, 0, 0, 0, 0, 0, 0);
    send_tick(-1000000, -50000, 180000, 0, 20000, 20000, -20000, -20000, 0, -9000, 300000);
    send_tick(5, 1, 1, 1, 0, 0, 0, 0, 1, 0, 0);
    send_tick(5, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    send_tick(5, 1, 1, 1, 0, 0, 0, 0, 1, 0, 0);
    send_tick(5, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0);

    drift_height = 0;
    drift_roll = 0;
    drift_pitch = 0;
    drift_yaw = 0;
    drift_cam = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE);
      load_phase_regs(ph);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off once mid-run until the block has fully drained
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) begin
          drain(0);
        end
        random_tick();
      end
    end

    receiver_stall_pct = 0;
    drain(SETTLE);
    $display("ran %0d ticks through %0d register settings under four flow patterns",
             ticks_sent, PHASES + 1);
    $display("checked %0d results, %0d of them with rotors on", results_seen, powered_seen);
    if (fail_count == 0) begin
      $display("[quadrotor_attitude_pd_mixer] OK");
    end else begin
      $display("[quadrotor_attitude_pd_mixer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
